/* sv/lcdws_pkg.sv */
// Shared types and constants for the character-LCD write sequencer.
`default_nettype none
package lcdws_pkg;

  localparam int DISPLAY_COLUMNS_DEF = 20;
  localparam int QUEUE_DEPTH_DEF     = 4;

  typedef enum logic [2:0] {
    OP_COMMAND   = 3'd0,
    OP_CHAR      = 3'd1,
    OP_CHAR_AT   = 3'd2,
    OP_INIT      = 3'd3,
    OP_GLYPH_ROW = 3'd4
  } op_e;

  localparam logic CFG_FOUR_BIT_MODE   = 1'b0;
  localparam logic CFG_ENABLE_PULSE_US = 1'b1;

  localparam logic [14:0] HOLD_POWER_UP  = 15'd20000;
  localparam logic [14:0] HOLD_FIRST_SET = 15'd5000;
  localparam logic [14:0] HOLD_SECOND_SET = 15'd150;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] value;
    logic [2:0] row;
    logic [4:0] column;
    logic [2:0] glyph_slot;
    logic [2:0] pattern_row;
  } req_t;

  typedef struct packed {
    logic        reg_select;
    logic        enable_pin;
    logic [7:0]  data_bus;
    logic [14:0] hold_us;
    logic        last_step;
  } step_t;

  // One word of work for the pin driver: a byte to clock out, or a bare wait.
  typedef struct packed {
    logic        is_wait;
    logic        rs;
    logic [7:0]  data;
    logic [14:0] tail_hold;
    logic        last;
  } entry_t;

endpackage
`default_nettype wire

/* sv/lcdws_front.sv */
// Request decoder: splits a request into byte and wait queue words.
`default_nettype none
module lcdws_front #(
  parameter int DISPLAY_COLUMNS = lcdws_pkg::DISPLAY_COLUMNS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire lcdws_pkg::req_t   req,
  input  wire logic              four_bit_mode,
  input  wire logic              queue_full,
  output logic                   push,
  output lcdws_pkg::entry_t      push_entry
);
  import lcdws_pkg::*;

  // wide enough for both the column field and the column limit
  localparam int COL_W = ($clog2(DISPLAY_COLUMNS + 1) > 5) ? $clog2(DISPLAY_COLUMNS + 1) : 5;

  logic       active;
  req_t       item;
  logic [3:0] idx;

  logic       present;
  logic [3:0] final_idx;
  logic       advance;
  logic       is_final;
  logic       accept;
  logic       row_ok;
  logic [7:0] cursor_cmd;
  logic [7:0] row_base;
  logic [COL_W-1:0] col_c;
  logic [COL_W-1:0] col_in;
  entry_t     ent;

  // Cursor address from row base and clamped column
  always_comb begin
    col_in = COL_W'(item.column);
    if (col_in == '0) begin
      col_c = COL_W'(1);
    end else if (col_in > COL_W'(DISPLAY_COLUMNS)) begin
      col_c = COL_W'(DISPLAY_COLUMNS);
    end else begin
      col_c = col_in;
    end
    row_ok = 1'b1;
    case (item.row)
      3'd1: row_base = 8'h80;
      3'd2: row_base = 8'hC0;
      3'd3: row_base = 8'h94;
      3'd4: row_base = 8'hD4;
      default: begin
        row_base = 8'h00;
        row_ok   = 1'b0;
      end
    endcase
    cursor_cmd = row_base + 8'(col_c) - 8'd1;
  end

  always_comb begin
    ent           = '0;
    present       = 1'b1;
    final_idx     = 4'd0;
    case (op_e'(item.operation))
      OP_COMMAND: begin
        ent.data = item.value;
      end
      OP_CHAR: begin
        ent.rs   = 1'b1;
        ent.data = item.value;
      end
      OP_CHAR_AT: begin
        final_idx = 4'd1;
        if (idx == 4'd0) begin
          present  = row_ok;
          ent.data = cursor_cmd;
        end else begin
          ent.rs   = 1'b1;
          ent.data = item.value;
        end
      end
      OP_INIT: begin
        final_idx = 4'd9;
        case (idx)
          4'd0: begin
            ent.is_wait   = 1'b1;
            ent.tail_hold = HOLD_POWER_UP;
          end
          4'd1: begin
            ent.data      = 8'h38;
            ent.tail_hold = HOLD_FIRST_SET;
          end
          4'd2: begin
            ent.data      = 8'h38;
            ent.tail_hold = HOLD_SECOND_SET;
          end
          4'd3: ent.data = 8'h38;
          4'd4: ent.data = 8'h01;
          4'd5: ent.data = 8'h02;
          4'd6: ent.data = 8'h06;
          4'd7: ent.data = 8'h0C;
          4'd8: ent.data = four_bit_mode ? 8'h28 : 8'h38;
          default: ent.data = 8'h80;
        endcase
      end
      OP_GLYPH_ROW: begin
        final_idx = (item.pattern_row == 3'd7) ? 4'd3 : 4'd1;
        case (idx)
          4'd0: begin
            present  = (item.pattern_row == 3'd0);
            ent.data = 8'h40 + {2'b00, item.glyph_slot, 3'b000};
          end
          4'd1: begin
            ent.rs   = 1'b1;
            ent.data = item.value;
          end
          4'd2: begin
            present  = row_ok;
            ent.data = cursor_cmd;
          end
          default: begin
            ent.rs   = 1'b1;
            ent.data = {5'b00000, item.glyph_slot};
          end
        endcase
      end
      default: present = 1'b0;
    endcase
    ent.last = (idx == final_idx);
  end

  assign push       = active && present && !queue_full;
  assign advance    = active && (!present || !queue_full);
  assign is_final   = (idx == final_idx);
  assign busy       = active && !(advance && is_final);
  assign accept     = start && !busy;
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= 4'd0;
    end else if (accept) begin
      // drop unused operation codes at the door
      active <= (req.operation <= 3'(OP_GLYPH_ROW));
      idx    <= 4'd0;
    end else if (advance) begin
      if (is_final) begin
        active <= 1'b0;
      end
      idx <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
  end

endmodule
`default_nettype wire

/* sv/lcdws_queue.sv */
// Short word queue between the request decoder and the pin driver.
`default_nettype none
module lcdws_queue #(
  parameter int DEPTH = lcdws_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire lcdws_pkg::entry_t  push_entry,
  input  wire logic               pop,
  output lcdws_pkg::entry_t       head,
  output logic                    full,
  output logic                    empty
);
  import lcdws_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> !empty)
    else $error("pushed word not held");
  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    do_pop && !do_push && (count == CNT_W'(1)) |=> empty)
    else $error("last word not drained");

endmodule
`default_nettype wire

/* sv/lcdws_back.sv */
// Pin driver: each queued word becomes pulses or a wait, one pin step a cycle.
`default_nettype none
module lcdws_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lcdws_pkg::entry_t  head,
  input  wire logic               empty,
  output logic                    pop,
  input  wire logic               four_bit_mode,
  input  wire logic [7:0]         enable_pulse_us,
  output logic                    step_valid,
  output lcdws_pkg::step_t        step
);
  import lcdws_pkg::*;

  entry_t     cur;
  logic       cur_valid;
  logic [1:0] phase;
  logic [1:0] final_phase;
  logic       at_final;
  step_t      step_next;
  logic [3:0] nib;

  always_comb begin
    if (cur.is_wait) begin
      final_phase = 2'd0;
    end else if (four_bit_mode) begin
      final_phase = 2'd3;
    end else begin
      final_phase = 2'd1;
    end
    at_final = (phase == final_phase);
    pop      = !empty && (!cur_valid || at_final);
    nib      = phase[1] ? cur.data[3:0] : cur.data[7:4];

    step_next = '0;
    if (cur.is_wait) begin
      step_next.hold_us = cur.tail_hold;
    end else begin
      step_next.reg_select = cur.rs;
      step_next.enable_pin = !phase[0];
      step_next.data_bus   = four_bit_mode ? {4'b0000, nib} : cur.data;
      if (!phase[0]) begin
        step_next.hold_us = {7'd0, enable_pulse_us};
      end else if (at_final) begin
        step_next.hold_us = cur.tail_hold;
      end
    end
    step_next.last_step = cur.last && at_final;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      phase      <= 2'd0;
      step_valid <= 1'b0;
    end else begin
      step_valid <= cur_valid;
      if (pop) begin
        cur_valid <= 1'b1;
        phase     <= 2'd0;
      end else if (cur_valid) begin
        // advance through the pulse, release the word on its final step
        if (at_final) begin
          cur_valid <= 1'b0;
        end
        phase <= phase + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    step <= step_next;
  end

  a_enable_falls: assert property (@(posedge clk) disable iff (rst)
    step_valid && step.enable_pin |=> step_valid && !step.enable_pin)
    else $error("enable high step not followed by its low step");
  a_last_low: assert property (@(posedge clk) disable iff (rst)
    step_valid && step.last_step |-> !step.enable_pin)
    else $error("request ends with enable high");
  a_strobe_source: assert property (@(posedge clk) disable iff (rst)
    step_valid |-> $past(cur_valid))
    else $error("step strobe without a word in progress");

endmodule
`default_nettype wire

/* sv/char_lcd_write_sequencer.sv */
// Top level: config registers, request decoder, word queue and pin driver.
// With the queue idle, a request passes the decoder's request register, the queue and
// the pin driver's word and step registers before its first pin step strobes.
// Throughput: one pin step per cycle, the receiver cannot stall; a byte is 4 steps in
// 4-bit mode, 2 in 8-bit mode, so the pin driver sets the rate; initialize is 37 or 19.
// busy holds off requests while the decoder still has words for the queue.
// Reset: 4-bit mode, 5 us enable pulse, queue empty, no step pending.
`default_nettype none
module char_lcd_write_sequencer #(
  parameter int DISPLAY_COLUMNS = lcdws_pkg::DISPLAY_COLUMNS_DEF,
  parameter int QUEUE_DEPTH     = lcdws_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire lcdws_pkg::req_t   req,
  output logic                   step_valid,
  output lcdws_pkg::step_t       step,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [7:0]        cfg_data
);
  import lcdws_pkg::*;

  logic       four_bit_mode;
  logic [7:0] enable_pulse_us;
  logic       q_push;
  entry_t     q_push_entry;
  logic       q_pop;
  entry_t     q_head;
  logic       q_full;
  logic       q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      four_bit_mode   <= 1'b1;
      enable_pulse_us <= 8'd5;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FOUR_BIT_MODE:   four_bit_mode   <= cfg_data[0];
        CFG_ENABLE_PULSE_US: enable_pulse_us <= cfg_data;
        default: ;
      endcase
    end
  end

  lcdws_front #(
    .DISPLAY_COLUMNS (DISPLAY_COLUMNS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req           (req),
    .four_bit_mode (four_bit_mode),
    .queue_full    (q_full),
    .push          (q_push),
    .push_entry    (q_push_entry)
  );

  lcdws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  lcdws_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (q_head),
    .empty           (q_empty),
    .pop             (q_pop),
    .four_bit_mode   (four_bit_mode),
    .enable_pulse_us (enable_pulse_us),
    .step_valid      (step_valid),
    .step            (step)
  );

endmodule
`default_nettype wire

/* test/lcdws_step_checker.sv */
// Checker for the LCD write sequencer: predicts pin steps per request and compares them.
`timescale 1ns / 1ps
module lcdws_step_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  lcdws_pkg::req_t   req,
  input  logic              step_valid,
  input  lcdws_pkg::step_t  step,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  output int                mismatches,
  output int                steps_due
);
  import lcdws_pkg::*;

  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] CMD_HOME         = 8'h02;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_FUNC_4BIT    = 8'h28;
  localparam logic [7:0] CMD_FUNC_8BIT    = 8'h38;
  localparam logic [7:0] CMD_SET_CGRAM    = 8'h40;
  localparam logic [7:0] ROW1_BASE        = 8'h80;
  localparam logic [7:0] ROW2_BASE        = 8'hC0;
  localparam logic [7:0] ROW3_BASE        = 8'h94;
  localparam logic [7:0] ROW4_BASE        = 8'hD4;
  localparam logic       RS_INSTR         = 1'b0;
  localparam logic       RS_DATA          = 1'b1;

  logic        four_bit_mode;
  logic [7:0]  pulse_us;
  step_t       steps_expected[$];

  task automatic push_step(input logic rs, input logic en, input logic [7:0] bus,
                           input logic [14:0] hold);
    step_t s;
    s.reg_select = rs;
    s.enable_pin = en;
    s.data_bus   = bus;
    s.hold_us    = hold;
    s.last_step  = 1'b0;
    steps_expected.push_back(s);
  endtask

  task automatic push_pulse(input logic rs, input logic [7:0] bus, input logic [14:0] tail);
    push_step(rs, 1'b1, bus, {7'd0, pulse_us});
    push_step(rs, 1'b0, bus, tail);
  endtask

  task automatic push_byte(input logic rs, input logic [7:0] b, input logic [14:0] tail);
    if (four_bit_mode) begin
      push_pulse(rs, {4'h0, b[7:4]}, 15'd0);
      push_pulse(rs, {4'h0, b[3:0]}, tail);
    end else begin
      push_pulse(rs, b, tail);
    end
  endtask

  task automatic push_cursor(input logic [2:0] row, input logic [4:0] column);
    logic [7:0] col;
    logic [7:0] base;
    col = {3'd0, column};
    if (col < 8'd1) col = 8'd1;
    if (col > DISPLAY_COLUMNS_DEF) col = 8'(DISPLAY_COLUMNS_DEF);
    case (row)
      3'd1: base = ROW1_BASE;
      3'd2: base = ROW2_BASE;
      3'd3: base = ROW3_BASE;
      3'd4: base = ROW4_BASE;
      default: return;  // drop cursor move for rows off the display
    endcase
    push_byte(RS_INSTR, base + col - 8'd1, 15'd0);
  endtask

  task automatic predict_steps(input req_t r);
    int    depth_before;
    step_t tail_step;
    depth_before = steps_expected.size();
    case (r.operation)
      OP_COMMAND: push_byte(RS_INSTR, r.value, 15'd0);
      OP_CHAR:    push_byte(RS_DATA, r.value, 15'd0);
      OP_CHAR_AT: begin
        push_cursor(r.row, r.column);
        push_byte(RS_DATA, r.value, 15'd0);
      end
      OP_INIT: begin
        push_step(RS_INSTR, 1'b0, 8'h00, HOLD_POWER_UP);
        push_byte(RS_INSTR, CMD_FUNC_8BIT, HOLD_FIRST_SET);
        push_byte(RS_INSTR, CMD_FUNC_8BIT, HOLD_SECOND_SET);
        push_byte(RS_INSTR, CMD_FUNC_8BIT, 15'd0);
        push_byte(RS_INSTR, CMD_CLEAR, 15'd0);
        push_byte(RS_INSTR, CMD_HOME, 15'd0);
        push_byte(RS_INSTR, CMD_ENTRY_MODE, 15'd0);
        push_byte(RS_INSTR, CMD_DISPLAY_ON, 15'd0);
        push_byte(RS_INSTR, four_bit_mode ? CMD_FUNC_4BIT : CMD_FUNC_8BIT, 15'd0);
        push_byte(RS_INSTR, ROW1_BASE, 15'd0);
      end
      OP_GLYPH_ROW: begin
        if (r.pattern_row == 3'd0)
          push_byte(RS_INSTR, CMD_SET_CGRAM + {2'b00, r.glyph_slot, 3'b000}, 15'd0);
        push_byte(RS_DATA, r.value, 15'd0);
        // the final pattern row also places the finished glyph
        if (r.pattern_row == 3'd7) begin
          push_cursor(r.row, r.column);
          push_byte(RS_DATA, {5'd0, r.glyph_slot}, 15'd0);
        end
      end
      default: ;
    endcase
    if (steps_expected.size() > depth_before) begin
      tail_step = steps_expected.pop_back();
      tail_step.last_step = 1'b1;
      steps_expected.push_back(tail_step);
    end
  endtask

  function automatic int field_differs(input string name, input int unsigned want,
                                       input int unsigned got);
    if (want == got) return 0;
    $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin : watch
    step_t want;
    int    bad;
    bad = 0;
    if (rst) begin
      four_bit_mode = 1'b1;
      pulse_us      = 8'd5;
      steps_expected.delete();
    end else begin
      if (step_valid) begin
        if (steps_expected.size() == 0) begin
          $error("step word with none expected: 0x%0h", step);
          bad++;
        end else begin
          want = steps_expected.pop_front();
          bad += field_differs("reg_select", want.reg_select, step.reg_select);
          bad += field_differs("enable_pin", want.enable_pin, step.enable_pin);
          bad += field_differs("data_bus", want.data_bus, step.data_bus);
          bad += field_differs("hold_us", want.hold_us, step.hold_us);
          bad += field_differs("last_step", want.last_step, step.last_step);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FOUR_BIT_MODE) four_bit_mode = cfg_data[0];
        else pulse_us = cfg_data;
      end
      if (start && !busy) predict_steps(req);
    end
    mismatches <= mismatches + bad;
    steps_due  <= steps_expected.size();
  end

endmodule

/* test/tb_top.sv */
// Testbench top: drives requests and register writes into the LCD write sequencer.
`timescale 1ns / 1ps
module tb_top;
  import lcdws_pkg::*;

  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 112;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  req_t       req;
  logic       step_valid;
  step_t      step;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [7:0] cfg_data;
  int         mismatches;
  int         steps_due;
  int         items_sent;
  int         quiet_cycles;

  char_lcd_write_sequencer u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .step_valid(step_valid),
    .step      (step),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lcdws_step_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .step_valid(step_valid),
    .step      (step),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mismatches(mismatches),
    .steps_due (steps_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic req_t make_req(input logic [2:0] op, input logic [7:0] value,
                                    input logic [2:0] row, input logic [4:0] column,
                                    input logic [2:0] slot, input logic [2:0] prow);
    req_t r;
    r.operation   = op;
    r.value       = value;
    r.row         = row;
    r.column      = column;
    r.glyph_slot  = slot;
    r.pattern_row = prow;
    return r;
  endfunction

  // mostly on-screen rows, now and then one that skips the cursor move
  function automatic logic [2:0] pick_row();
    if ($urandom_range(99) < 80) return 3'($urandom_range(1, 4));
    return 3'($urandom_range(7));
  endfunction

  function automatic logic [4:0] pick_column();
    if ($urandom_range(99) < 80) return 5'($urandom_range(1, DISPLAY_COLUMNS_DEF));
    return 5'($urandom_range(31));
  endfunction

  task automatic send_request(input req_t r);
    int idle_pct;
    idle_pct = (items_sent < 180) ? 29 : (items_sent < 340) ? 52 : 0;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // hold off until every predicted step has come out, then let the block settle
  task automatic drain_steps();
    start <= 1'b0;
    @(posedge clk);
    while (steps_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic four, input logic [7:0] pulse);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FOUR_BIT_MODE;
    cfg_data  <= {7'd0, four};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_ENABLE_PULSE_US;
    cfg_data  <= pulse;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_unit();
    int         pick;
    logic [2:0] slot;
    pick = $urandom_range(99);
    if (pick < 15) begin
      // whole glyph definition: pattern rows in order, one slot
      slot = 3'($urandom_range(7));
      for (int i = 0; i < 8; i++)
        send_request(make_req(OP_GLYPH_ROW, 8'($urandom), pick_row(), pick_column(),
                              slot, 3'(i)));
    end else if (pick < 33) begin
      send_request(make_req(OP_COMMAND, 8'($urandom), 3'($urandom), 5'($urandom),
                            3'($urandom), 3'($urandom)));
    end else if (pick < 52) begin
      send_request(make_req(OP_CHAR, 8'($urandom), 3'($urandom), 5'($urandom),
                            3'($urandom), 3'($urandom)));
    end else if (pick < 78) begin
      send_request(make_req(OP_CHAR_AT, 8'($urandom), pick_row(), pick_column(),
                            3'($urandom), 3'($urandom)));
    end else if (pick < 82) begin
      send_request(make_req(OP_INIT, 8'($urandom), 3'($urandom), 5'($urandom),
                            3'($urandom), 3'($urandom)));
    end else if (pick < 95) begin
      send_request(make_req(OP_GLYPH_ROW, 8'($urandom), pick_row(), pick_column(),
                            3'($urandom), 3'($urandom)));
    end else begin
      send_request(make_req(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                            8'($urandom), 3'($urandom), 5'($urandom),
                            3'($urandom), 3'($urandom)));
    end
    if ($urandom_range(49) == 0) drain_steps();
  endtask

  // stop the run when no request, register write or pin step is seen for too long
  always @(posedge clk) begin
    if ((start && !busy) || step_valid || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    req          = '0;
    cfg_valid    = 1'b0;
    cfg_index    = 1'b0;
    cfg_data     = 8'd0;
    items_sent   = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset mode: four-bit bus, 5 us enable pulse
    send_request(make_req(OP_COMMAND, 8'h00, 3'd0, 5'd0, 3'd0, 3'd0));
    send_request(make_req(OP_COMMAND, 8'hFF, 3'd7, 5'd31, 3'd7, 3'd7));
    send_request(make_req(OP_CHAR, 8'hA5, 3'd1, 5'd1, 3'd0, 3'd0));
    send_request(make_req(OP_CHAR, 8'h5A, 3'd1, 5'd1, 3'd0, 3'd0));
    send_request(make_req(OP_CHAR_AT, 8'h41, 3'd1, 5'd1, 3'd0, 3'd0));
    send_request(make_req(OP_CHAR_AT, 8'h42, 3'd2, 5'd20, 3'd0, 3'd0));
    send_request(make_req(OP_CHAR_AT, 8'h43, 3'd3, 5'd0, 3'd0, 3'd0));
    send_request(make_req(OP_CHAR_AT, 8'h44, 3'd4, 5'd31, 3'd0, 3'd0));
    send_request(make_req(OP_CHAR_AT, 8'h45, 3'd0, 5'd5, 3'd0, 3'd0));
    send_request(make_req(OP_CHAR_AT, 8'h46, 3'd7, 5'd5, 3'd0, 3'd0));
    send_request(make_req(OP_INIT, 8'h00, 3'd0, 5'd0, 3'd0, 3'd0));
    send_request(make_req(OP_GLYPH_ROW, 8'h1F, 3'd1, 5'd1, 3'd7, 3'd0));
    send_request(make_req(OP_GLYPH_ROW, 8'h0A, 3'd1, 5'd1, 3'd2, 3'd3));
    send_request(make_req(OP_GLYPH_ROW, 8'h15, 3'd4, 5'd20, 3'd7, 3'd7));
    send_request(make_req(OP_GLYPH_ROW, 8'h11, 3'd5, 5'd3, 3'd1, 3'd7));
    send_request(make_req(OP_SPARE_FIRST, 8'h77, 3'd1, 5'd1, 3'd0, 3'd0));
    send_request(make_req(OP_SPARE_LAST, 8'h88, 3'd2, 5'd2, 3'd0, 3'd0));

    for (int p = 0; p < 4; p++) begin
      drain_steps();
      case (p)
        0: set_mode(1'b0, 8'd255);
        1: set_mode(1'b1, 8'd1);
        2: set_mode(1'b0, 8'd0);
        default: set_mode(1'b1, 8'($urandom_range(1, 254)));
      endcase
      if (p == 0) begin
        send_request(make_req(OP_INIT, 8'h00, 3'd0, 5'd0, 3'd0, 3'd0));
        send_request(make_req(OP_CHAR_AT, 8'h7E, 3'd2, 5'd21, 3'd0, 3'd0));
        send_request(make_req(OP_GLYPH_ROW, 8'h0E, 3'd1, 5'd1, 3'd5, 3'd0));
        send_request(make_req(OP_GLYPH_ROW, 8'h04, 3'd3, 5'd10, 3'd5, 3'd7));
      end
      while (items_sent < 21 + (p + 1) * PHASE_ITEMS) send_random_unit();
    end

    drain_steps();
    if (mismatches == 0 && steps_due == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule

/* char_lcd_write_sequencer.f */
sv/lcdws_pkg.sv
sv/lcdws_front.sv
sv/lcdws_queue.sv
sv/lcdws_back.sv
sv/char_lcd_write_sequencer.sv
test/lcdws_step_checker.sv
test/tb_top.sv
